/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deque RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Sizes, opcode and status codes shared by the deque channels and core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   // capacity and stored payload width
   localparam int Depth            = 16;
   localparam int PayloadWidth     = 64;

   // fixed channel field widths
   localparam int OpWidth          = 3;
   localparam int TagWidth         = 32;
   localparam int PayloadPortWidth = 64;
   localparam int StatusWidth      = 2;

   // derived widths
   localparam int IndexWidth       = $clog2(Depth);
   localparam int CountWidth       = $clog2(Depth + 1);

   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [CountWidth-1:0] count_type;

   // operation codes
   typedef enum logic [OpWidth-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_NOP        = 3'd7
   } op_type;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/deq_req_if.sv */
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: opcode, tag and payload with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
   import deq_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OpWidth-1:0]          opcode;
   logic signed [TagWidth-1:0]  entry_tag;
   logic [PayloadPortWidth-1:0] entry_payload;

   modport source (
      output valid, opcode, entry_tag, entry_payload,
      input  ready
   );

   modport sink (
      input  valid, opcode, entry_tag, entry_payload,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/deq_rsp_if.sv */
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: status, read entry and count with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
   import deq_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [StatusWidth-1:0]      status;
   logic signed [TagWidth-1:0]  read_tag;
   logic [PayloadPortWidth-1:0] read_payload;
   logic [CountWidth-1:0]       item_count;

   modport source (
      output valid, status, read_tag, read_payload, item_count,
      input  ready
   );

   modport sink (
      input  valid, status, read_tag, read_payload, item_count,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of tagged payload entries kept in a register ring. Each
// request beat carries one operation (push, pop or peek at either end, clear
// or no-op) and returns exactly one response beat with a status, the entry
// read by a pop or peek (zero otherwise) and the entry count afterwards.
// A push to a full deque reports full, a pop or peek on an empty one reports
// empty; neither changes any state. The block takes one operation per clock
// while the response side accepts, and passes each one through a request
// register, then a response register; that rate is set by the front index and
// count update, which each operation completes before the next. Backpressure on the
// response side stalls the request side only once both registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);
   import deq_pkg::*;

   // ring slot of front plus offset, offset below Depth
   function automatic index_type slot_add(input index_type base, input count_type offset);
      logic [CountWidth:0] sum;
      sum = (CountWidth + 1)'(base) + (CountWidth + 1)'(offset);
      if (sum >= (CountWidth + 1)'(Depth)) begin
         sum = sum - (CountWidth + 1)'(Depth);
      end
      return sum[IndexWidth-1:0];
   endfunction

   // request stage
   logic                       s1_valid_ff;
   op_type                     s1_op_ff;
   logic signed [TagWidth-1:0] s1_tag_ff;
   logic [PayloadWidth-1:0]    s1_payload_ff;

   // response stage
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic signed [TagWidth-1:0] rsp_tag_ff;
   logic [PayloadWidth-1:0]    rsp_payload_ff;
   count_type                  rsp_count_ff;

   // deque state
   index_type                  front_ff;
   count_type                  count_ff;
   logic signed [TagWidth-1:0] tag_store_ff     [Depth];
   logic [PayloadWidth-1:0]    payload_store_ff [Depth];

   // next values
   index_type                  front_in;
   count_type                  count_in;
   status_type                 status_in;
   logic signed [TagWidth-1:0] read_tag_in;
   logic [PayloadWidth-1:0]    read_payload_in;
   logic                       wr_en;
   index_type                  wr_slot;
   index_type                  rd_slot;

   // helper values
   index_type                  front_dec;
   index_type                  front_inc;
   index_type                  tail_slot;
   index_type                  last_slot;
   logic                       is_full;
   logic                       is_empty;
   logic                       advance;
   logic                       req_take;

   // handshake
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // ring positions
   assign front_dec = (front_ff == '0) ? IndexWidth'(Depth - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IndexWidth'(Depth - 1)) ? '0 : front_ff + 1'b1;
   assign tail_slot = slot_add(front_ff, count_ff);
   assign last_slot = slot_add(front_ff, count_ff - 1'b1);
   assign is_full   = (count_ff == CountWidth'(Depth));
   assign is_empty  = (count_ff == '0);

   // operation decode and next state
   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      status_in       = ST_OK;
      read_tag_in     = '0;
      read_payload_in = '0;
      wr_en           = 1'b0;
      wr_slot         = tail_slot;
      rd_slot         = front_ff;
      unique case (s1_op_ff) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (s1_op_ff == OP_PUSH_FRONT) begin
                  front_in = front_dec;
                  wr_slot  = front_dec;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               if (s1_op_ff == OP_POP_BACK || s1_op_ff == OP_PEEK_BACK) begin
                  rd_slot = last_slot;
               end
               read_tag_in     = tag_store_ff[rd_slot];
               read_payload_in = payload_store_ff[rd_slot];
               if (s1_op_ff == OP_POP_FRONT) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end else if (s1_op_ff == OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
               // an emptied deque restarts at slot zero
               if (count_in == '0) begin
                  front_in = '0;
               end
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         front_ff     <= '0;
         count_ff     <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            front_ff     <= front_in;
            count_ff     <= count_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers and entry store
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff      <= op_type'(req_chan.opcode);
         s1_tag_ff     <= req_chan.entry_tag;
         s1_payload_ff <= req_chan.entry_payload[PayloadWidth-1:0];
      end
      if (advance) begin
         rsp_status_ff  <= status_in;
         rsp_tag_ff     <= read_tag_in;
         rsp_payload_ff <= read_payload_in;
         rsp_count_ff   <= count_in;
      end
      if (advance && wr_en) begin
         tag_store_ff[wr_slot]     <= s1_tag_ff;
         payload_store_ff[wr_slot] <= s1_payload_ff;
      end
   end

   // response beat
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.read_tag     = rsp_tag_ff;
   assign rsp_chan.read_payload = PayloadPortWidth'(rsp_payload_ff);
   assign rsp_chan.item_count   = rsp_count_ff;

   // checks
   `ASSERT_CLK(a_full_at_capacity, clock, reset, (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == CountWidth'(Depth)), "full reported below capacity")
   `ASSERT_CLK(a_empty_at_zero, clock, reset, (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_count_ff == '0), "empty reported with entries held")
   `ASSERT_NEVER(a_front_home, clock, reset, (count_ff == '0) && (front_ff != '0), "empty deque with front away from slot zero")
   `ASSERT_CLK(a_pop_count, clock, reset, (advance && s1_op_ff == OP_POP_FRONT && count_ff != '0) |=> (count_ff == $past(count_ff) - 1'b1), "pop front did not drop the count by one")

endmodule

`default_nettype wire
